// ----- sv/pet_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pet_pkg;

  localparam int NUM_W     = 9;
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 7;
  localparam int DIVR_W    = 5;
  localparam int SQ_W      = 10;
  localparam int MAX_RESULTS = 64;
  localparam int DIV_STEPS = 9;
  localparam int STEP_W    = 4;

  typedef struct packed {
    logic load;
    logic cand_init;
    logic div_start;
    logic d_step;
    logic n_step;
    logic take_prime;
    logic emit_pend;
    logic emit_none;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic lim_lt2;
    logic cand_over;
    logic root_over;
    logic div_done;
    logic rem_zero;
    logic count_full;
    logic have_pend;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- sv/pet_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pet_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [pet_pkg::NUM_W-1:0]   dividend,
  input  wire logic [pet_pkg::DIVR_W-1:0]  divisor,
  output logic                             done,
  output logic [pet_pkg::DIVR_W-1:0]       rem
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [pet_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [pet_pkg::NUM_W-1:0]     shift_r, shift_nxt;
  logic [pet_pkg::DIVR_W-1:0]    rem_r, rem_nxt;
  logic [pet_pkg::DIVR_W-1:0]    div_r, div_nxt;
  logic [pet_pkg::DIVR_W:0]      trial;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    trial     = {rem_r, shift_r[pet_pkg::NUM_W-1]};
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = pet_pkg::STEP_W'(pet_pkg::DIV_STEPS);
      shift_nxt = dividend;
      rem_nxt   = '0;
      div_nxt   = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = pet_pkg::DIVR_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = pet_pkg::DIVR_W'(trial);
      end
      shift_nxt = {shift_r[pet_pkg::NUM_W-2:0], 1'b0};
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == pet_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ----- sv/pet_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pet_datapath #(
  parameter int MAX_LIMIT = 311
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pet_pkg::cmd_t               cmd,
  output pet_pkg::status_t                 status,
  input  wire logic [pet_pkg::NUM_W-1:0]   in_limit,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [pet_pkg::NUM_W-1:0]        out_prime,
  output logic [pet_pkg::POS_W-1:0]        out_position,
  output logic                             out_last,
  output logic                             out_none_found
);

  localparam logic [pet_pkg::NUM_W-1:0] LIM_CAP = pet_pkg::NUM_W'(MAX_LIMIT);

  logic [pet_pkg::NUM_W-1:0]   lim_r, n_r, pend_prime_r;
  logic [pet_pkg::DIVR_W-1:0]  d_r;
  logic [pet_pkg::SQ_W-1:0]    sq_r;
  logic [pet_pkg::COUNT_W-1:0] count_r;
  logic [pet_pkg::POS_W-1:0]   pend_pos_r;
  logic                        have_pend_r;
  logic                        out_valid_r;
  logic [pet_pkg::NUM_W-1:0]   out_prime_r;
  logic [pet_pkg::POS_W-1:0]   out_pos_r;
  logic                        out_last_r, out_none_r;
  logic [pet_pkg::NUM_W-1:0]   lim_sat;
  logic                        div_done;
  logic [pet_pkg::DIVR_W-1:0]  div_rem;

  assign lim_sat = (in_limit > LIM_CAP) ? LIM_CAP : in_limit;

  pet_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    status.lim_lt2    = (lim_r < pet_pkg::NUM_W'(2));
    status.cand_over  = (n_r > lim_r);
    status.root_over  = (sq_r > pet_pkg::SQ_W'(n_r));
    status.div_done   = div_done;
    status.rem_zero   = (div_rem == '0);
    status.count_full = (count_r == pet_pkg::COUNT_W'(pet_pkg::MAX_RESULTS - 1));
    status.have_pend  = have_pend_r;
    status.out_free   = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (cmd.load) begin
        have_pend_r <= 1'b0;
        count_r     <= '0;
      end else if (cmd.take_prime) begin
        have_pend_r <= 1'b1;
        count_r     <= count_r + 1'b1;
      end
      if (cmd.emit_pend || cmd.emit_none) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.load) begin
      lim_r <= lim_sat;
      n_r   <= pet_pkg::NUM_W'(2);
    end else if (cmd.n_step) begin
      n_r <= n_r + 1'b1;
    end
    if (cmd.cand_init) begin
      d_r  <= pet_pkg::DIVR_W'(2);
      sq_r <= pet_pkg::SQ_W'(4);
    end else if (cmd.d_step) begin
      d_r  <= d_r + 1'b1;
      sq_r <= sq_r + pet_pkg::SQ_W'({d_r, 1'b1});
    end
    if (cmd.take_prime) begin
      pend_prime_r <= n_r;
      pend_pos_r   <= count_r[pet_pkg::POS_W-1:0];
    end
    if (cmd.emit_pend) begin
      out_prime_r <= pend_prime_r;
      out_pos_r   <= pend_pos_r;
      out_last_r  <= cmd.emit_last;
      out_none_r  <= 1'b0;
    end else if (cmd.emit_none) begin
      out_prime_r <= '0;
      out_pos_r   <= '0;
      out_last_r  <= 1'b1;
      out_none_r  <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_prime      = out_prime_r;
  assign out_position   = out_pos_r;
  assign out_last       = out_last_r;
  assign out_none_found = out_none_r;

endmodule
`default_nettype wire

// ----- sv/pet_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pet_controller (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pet_pkg::status_t  status,
  output pet_pkg::cmd_t          cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_NEXT  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_PRIME = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (status.lim_lt2) begin
          if (status.out_free) begin
            cmd.emit_none = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (status.cand_over) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.cand_init = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.root_over) begin
          state_nxt = S_PRIME;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            cmd.n_step = 1'b1;
            state_nxt  = S_NEXT;
          end else begin
            cmd.d_step = 1'b1;
            state_nxt  = S_CHECK;
          end
        end
      end
      S_PRIME: begin
        if (!status.have_pend || status.out_free) begin
          cmd.emit_pend  = status.have_pend;
          cmd.take_prime = 1'b1;
          cmd.n_step     = 1'b1;
          state_nxt      = status.count_full ? S_FLUSH : S_NEXT;
        end
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.emit_pend = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/prime_enumerator_trial_division_top.sv -----
// prime enumerator by trial division
// input channel: one beat carries in_limit; values above MAX_LIMIT are taken as MAX_LIMIT.
// in_stall is high while a run is in progress; a new beat is taken only between runs,
// though the final result of the previous run may still wait in the output register.
// result channel: one beat per prime, ascending, with out_position counting from zero
// and out_last on the final beat; a limit below two gives a single beat with
// out_none_found and out_last set and prime and position zero.
// each prime is held back one step so that out_last can be set on the true final prime,
// so the first result appears only once the next prime (or the end of the range) is found.
// each trial division runs on a shared restoring divider, one quotient bit a cycle.
// a stalled receiver holds the output register; the run pauses whenever a new result
// is ready and the previous one has not been taken.
// synchronous active-low reset returns the controller to idle and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none
module prime_enumerator_trial_division_top #(
  parameter int MAX_LIMIT = 311
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [pet_pkg::NUM_W-1:0]  in_limit,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [pet_pkg::NUM_W-1:0]       out_prime,
  output logic [pet_pkg::POS_W-1:0]       out_position,
  output logic                            out_last,
  output logic                            out_none_found
);

  pet_pkg::cmd_t    cmd;
  pet_pkg::status_t status;

  pet_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pet_datapath #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_limit       (in_limit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_prime      (out_prime),
    .out_position   (out_position),
    .out_last       (out_last),
    .out_none_found (out_none_found)
  );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int MAX_LIM = 311;
  localparam int N_DIRECTED = 21;
  localparam int N_RANDOM = 80;

  typedef struct packed {
    logic [pet_pkg::NUM_W-1:0] prime;
    logic [pet_pkg::POS_W-1:0] position;
    logic                      last;
    logic                      none_found;
  } prime_beat_t;

  typedef struct packed {
    logic [pet_pkg::NUM_W-1:0] limit;
    logic                      typed;
    prime_beat_t               beat;
  } limit_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [pet_pkg::NUM_W-1:0] in_limit = '0;
  logic out_stall = 1'b0;
  wire in_stall;
  wire out_valid;
  wire [pet_pkg::NUM_W-1:0] out_prime;
  wire [pet_pkg::POS_W-1:0] out_position;
  wire out_last;
  wire out_none_found;

  prime_beat_t expected_primes[$];
  limit_row_t limit_rows[N_DIRECTED];
  int mismatches = 0;
  int beats_taken = 0;

  prime_enumerator_trial_division_top #(.MAX_LIMIT(MAX_LIM)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_limit(in_limit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_prime(out_prime),
    .out_position(out_position),
    .out_last(out_last),
    .out_none_found(out_none_found)
  );

  always #4 clk = ~clk;

  function automatic void predict_primes(input logic [pet_pkg::NUM_W-1:0] lim);
    int top;
    int n;
    int d;
    int count;
    bit is_p;
    prime_beat_t b;
    top = (lim > MAX_LIM) ? MAX_LIM : int'(lim);
    if (top < 2) begin
      b = '{prime: '0, position: '0, last: 1'b1, none_found: 1'b1};
      expected_primes.push_back(b);
      return;
    end
    count = 0;
    for (n = 2; n <= top && count < pet_pkg::MAX_RESULTS; n++) begin
      is_p = 1'b1;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) is_p = 1'b0;
      end
      if (is_p) begin
        b.prime = n[pet_pkg::NUM_W-1:0];
        b.position = count[pet_pkg::POS_W-1:0];
        b.last = 1'b0;
        b.none_found = 1'b0;
        expected_primes.push_back(b);
        count++;
      end
    end
    expected_primes[expected_primes.size()-1].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [pet_pkg::NUM_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return pet_pkg::NUM_W'($urandom_range(0, 1));
    if (r < 70) return pet_pkg::NUM_W'($urandom_range(2, 63));
    if (r < 85) return pet_pkg::NUM_W'($urandom_range(64, MAX_LIM));
    return pet_pkg::NUM_W'($urandom_range(MAX_LIM + 1, 511));
  endfunction

  // starts and ends at a falling edge
  task automatic send_limit(input logic [pet_pkg::NUM_W-1:0] lim, input logic typed,
                            input prime_beat_t beat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      in_limit = pet_pkg::NUM_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_limit = lim;
    do @(posedge clk); while (in_stall);
    if (typed) expected_primes.push_back(beat);
    else predict_primes(lim);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    prime_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_taken++;
      if (expected_primes.size() == 0) begin
        $error("unexpected beat: prime %0d position %0d", out_prime, out_position);
        mismatches++;
      end else begin
        want = expected_primes.pop_front();
        if (out_prime !== want.prime) begin
          $error("prime: expected %0d, got %0d", want.prime, out_prime);
          mismatches++;
        end
        if (out_position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_position);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          mismatches++;
        end
        if (out_none_found !== want.none_found) begin
          $error("none_found: expected %0d, got %0d", want.none_found, out_none_found);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int stall_left;
    int calm_left;
    bit held_long;
    stall_left = 0;
    calm_left = 0;
    held_long = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held_long && beats_taken >= 40) begin
        held_long = 1'b1;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 7) == 0) stall_left = pick_gap();
        if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 300);
      end
    end
  end

  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    prime_beat_t no_beat;
    no_beat = '0;
    limit_rows = '{
      '{limit: 9'd0,   typed: 1'b1, beat: '{prime: 9'd0, position: 6'd0, last: 1'b1,
                                            none_found: 1'b1}},
      '{limit: 9'd1,   typed: 1'b1, beat: '{prime: 9'd0, position: 6'd0, last: 1'b1,
                                            none_found: 1'b1}},
      '{limit: 9'd2,   typed: 1'b1, beat: '{prime: 9'd2, position: 6'd0, last: 1'b1,
                                            none_found: 1'b0}},
      '{limit: 9'd3,   typed: 1'b0, beat: '0},
      '{limit: 9'd4,   typed: 1'b0, beat: '0},
      '{limit: 9'd5,   typed: 1'b0, beat: '0},
      '{limit: 9'd311, typed: 1'b0, beat: '0},
      '{limit: 9'd312, typed: 1'b0, beat: '0},
      '{limit: 9'd511, typed: 1'b0, beat: '0},
      '{limit: 9'd310, typed: 1'b0, beat: '0},
      '{limit: 9'd307, typed: 1'b0, beat: '0},
      '{limit: 9'd308, typed: 1'b0, beat: '0},
      '{limit: 9'd256, typed: 1'b0, beat: '0},
      '{limit: 9'd255, typed: 1'b0, beat: '0},
      '{limit: 9'd170, typed: 1'b0, beat: '0},
      '{limit: 9'd85,  typed: 1'b0, beat: '0},
      '{limit: 9'd100, typed: 1'b0, beat: '0},
      '{limit: 9'd6,   typed: 1'b0, beat: '0},
      '{limit: 9'd7,   typed: 1'b0, beat: '0},
      '{limit: 9'd11,  typed: 1'b0, beat: '0},
      '{limit: 9'd25,  typed: 1'b0, beat: '0}
    };
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (limit_rows[i]) begin
      send_limit(limit_rows[i].limit, limit_rows[i].typed, limit_rows[i].beat);
    end
    repeat (N_RANDOM) send_limit(pick_limit(), 1'b0, no_beat);
    in_valid = 1'b0;
    wait (expected_primes.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_primes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pet_pkg.sv
sv/pet_divider.sv
sv/pet_datapath.sv
sv/pet_controller.sv
sv/prime_enumerator_trial_division_top.sv
bench/tb_top.sv
